// File: hw/rtl/fva_pkg.sv
package fva_pkg;

   localparam int KEY_W    = 7;
   localparam int VEL_W    = 7;
   localparam int KEYS     = 128;
   localparam int VOICES   = 4;

   localparam logic [2:0] MODE_ROTATE   = 3'd0;
   localparam logic [2:0] MODE_REUSE    = 3'd1;
   localparam logic [2:0] MODE_RESET    = 3'd2;
   localparam logic [2:0] MODE_REASSIGN = 3'd3;
   localparam logic [2:0] MODE_UNISON   = 3'd4;

   localparam logic [2:0] NO_VOICE      = 3'd7;

   localparam logic [3:0] OP_NOTE_OFF   = 4'h8;
   localparam logic [3:0] OP_NOTE_ON    = 4'h9;
   localparam logic [3:0] OP_CTRL       = 4'hb;
   localparam logic [6:0] CC_SUSTAIN    = 7'h40;
   localparam logic [6:0] PEDAL_ON_MIN  = 7'd64;
   localparam logic [6:0] RESET_NOTE    = 7'd60;

   localparam logic [1:0] CSR_POLY_MODE      = 2'd0;
   localparam logic [1:0] CSR_CHANNEL_FILTER = 2'd1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] status_byte;
      logic [6:0] first_data;
      logic [6:0] second_data;
   } req_type;

   typedef struct packed {
      logic [6:0] note_zero;
      logic [6:0] note_one;
      logic [6:0] note_two;
      logic [6:0] note_three;
      logic       gate_zero;
      logic       gate_one;
      logic       gate_two;
      logic       gate_three;
      logic [6:0] velocity_zero;
      logic [6:0] velocity_one;
      logic [6:0] velocity_two;
      logic [6:0] velocity_three;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_PRESS,
      ST_SEARCH,
      ST_SHIFT,
      ST_VISSUE,
      ST_VAPPLY,
      ST_VEL,
      ST_DONE
   } state_type;

   // what the per-voice pass does after a release or pedal release
   typedef enum logic [2:0] {
      VK_REL_POP,
      VK_PED_POP,
      VK_REAS_REL,
      VK_REAS_PED,
      VK_UNISON
   } vkind_type;

endpackage

// File: hw/rtl/four_voice_note_allocator_core.sv
// Four-voice MIDI note allocator. One request (a channel message or a voice
// reset) goes in at a time and yields one response with each voice's note,
// gate and stored key velocity. Held and stolen notes live in a CACHE_DEPTH x 7
// stack RAM, per-key velocities in a 128 x 7 RAM with flip-flop valid bits, so
// no clearing pass is needed after reset. Steps per request: a decode step,
// then a note-on takes a press step; a release scans the stack at one entry a
// cycle and, on a hit, shifts the tail down one entry a cycle; the voice
// update pass does at most one RAM read per voice; then the velocity readout
// runs, and a last step loads the response register. The worst case from
// accept to a valid response is set by the stack scan and shift.
// The next request is taken as soon as the response is loaded, even while it
// waits on rsp_ready.
module four_voice_note_allocator_core #(
   parameter int CACHE_DEPTH = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fva_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fva_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [4:0]       csr_data
);

   localparam int AW = $clog2(CACHE_DEPTH);
   localparam int CW = $clog2(CACHE_DEPTH + 1);
   localparam int KAW = $clog2(fva_pkg::KEYS);

   // config registers
   logic [2:0] mode_ff, mode_in;
   logic [4:0] filter_ff, filter_in;

   // control
   fva_pkg::state_type state_ff, state_in;
   fva_pkg::vkind_type kind_ff, kind_in;
   fva_pkg::req_type   item_ff, item_in;
   logic [CW-1:0] count_ff, count_in;   // held_count
   logic [CW-1:0] scan_ff, scan_in;     // search / shift source pointer
   logic [AW-1:0] dst_ff, dst_in;       // shift destination
   logic          pend_ff, pend_in;     // stack read data valid
   logic [1:0]    vi_ff, vi_in;         // voice pass index
   logic [2:0]    vc_ff, vc_in;         // velocity readout counter

   // voices
   logic [6:0] note_ff [4];
   logic [6:0] note_in [4];
   logic       gate_ff [4];
   logic       gate_in [4];
   logic       pg_ff   [4];
   logic       pg_in   [4];
   logic       pedal_ff, pedal_in;
   logic [2:0] last_ff, last_in;
   logic [1:0] sp_ff, sp_in;

   // velocity readout
   logic [6:0] vout_ff [4];
   logic [6:0] vout_in [4];
   logic [fva_pkg::KEYS-1:0] vvalid_ff, vvalid_in;
   logic       vvld_rd_ff;

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   fva_pkg::rsp_type rsp_ff, rsp_in;

   // memories
   logic          st_we;
   logic [AW-1:0] st_waddr, st_raddr;
   logic [6:0]    st_wdata, st_rdata;
   logic          vm_we;
   logic [KAW-1:0] vm_waddr, vm_raddr;
   logic [6:0]    vm_wdata, vm_rdata;

   fva_ram #(.WIDTH(fva_pkg::KEY_W), .DEPTH(CACHE_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   fva_ram #(.WIDTH(fva_pkg::VEL_W), .DEPTH(fva_pkg::KEYS)) u_velocity (
      .clock   (clock),
      .wr_en   (vm_we),
      .wr_addr (vm_waddr),
      .wr_data (vm_wdata),
      .rd_addr (vm_raddr),
      .rd_data (vm_rdata)
   );

   // ------------------------------------------------------------------
   // request decode
   // ------------------------------------------------------------------
   logic [2:0] eff_mode;
   logic       chan_ok, is_on, is_off, is_ped;
   logic [3:0] opcode;

   assign eff_mode = (mode_ff > fva_pkg::MODE_UNISON) ? fva_pkg::MODE_RESET : mode_ff;
   assign opcode   = item_ff.status_byte[7:4];
   assign chan_ok  = (filter_ff == 5'd0) ||
                     ((filter_ff - 5'd1) == {1'b0, item_ff.status_byte[3:0]});
   assign is_on    = chan_ok && (opcode == fva_pkg::OP_NOTE_ON) && (item_ff.second_data != 7'd0);
   assign is_off   = chan_ok && ((opcode == fva_pkg::OP_NOTE_OFF) ||
                     ((opcode == fva_pkg::OP_NOTE_ON) && (item_ff.second_data == 7'd0)));
   assign is_ped   = chan_ok && (opcode == fva_pkg::OP_CTRL) &&
                     (item_ff.first_data == fva_pkg::CC_SUSTAIN);

   // ------------------------------------------------------------------
   // voice pick: first free voice after the start point, else steal
   // ------------------------------------------------------------------
   logic [1:0] pick_free, pick_steal, reuse_v;
   logic       pick_found, reuse_hit;

   always_comb begin : pick_logic
      logic [1:0] start;
      logic [1:0] cand;
      start = 2'd3;
      if ((eff_mode == fva_pkg::MODE_ROTATE) || (eff_mode == fva_pkg::MODE_REUSE)) begin
         start = (last_ff > 3'd3) ? 2'd3 : last_ff[1:0];
      end
      pick_found = 1'b0;
      pick_free  = 2'd0;
      for (int k = 1; k <= 4; k++) begin
         cand = start + 2'(k);
         if (!pick_found && !(gate_ff[cand] || pg_ff[cand])) begin
            pick_found = 1'b1;
            pick_free  = cand;
         end
      end
      pick_steal = sp_ff + 2'd1;
      reuse_hit  = 1'b0;
      reuse_v    = 2'd0;
      for (int i = 3; i >= 0; i--) begin
         if (note_ff[i] == item_ff.first_data) begin
            reuse_hit = 1'b1;
            reuse_v   = 2'(i);
         end
      end
   end

   // ------------------------------------------------------------------
   // shared sequencing flags
   // ------------------------------------------------------------------
   logic srch_match, srch_more, shift_more, vi_need_rd;

   assign srch_match = pend_ff && (st_rdata == item_ff.first_data);
   assign srch_more  = scan_ff < count_ff;
   assign shift_more = scan_ff < count_ff;

   always_comb begin
      vi_need_rd = 1'b0;
      unique case (kind_ff)
         fva_pkg::VK_REL_POP:  vi_need_rd = (note_ff[vi_ff] == item_ff.first_data) &&
                                            !pg_ff[vi_ff] && (count_ff != '0);
         fva_pkg::VK_PED_POP:  vi_need_rd = (count_ff != '0);
         fva_pkg::VK_REAS_REL,
         fva_pkg::VK_REAS_PED: vi_need_rd = CW'(vi_ff) < count_ff;
         fva_pkg::VK_UNISON:   vi_need_rd = (count_ff != '0);
         default:              vi_need_rd = 1'b0;
      endcase
   end

   // ------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fva_pkg::ST_IDLE: begin
            if (req_valid) state_in = fva_pkg::ST_DECODE;
         end
         fva_pkg::ST_DECODE: begin
            priority if (item_ff.cmd) state_in = fva_pkg::ST_VEL;
            else if (is_on)           state_in = fva_pkg::ST_PRESS;
            else if (is_off)          state_in = fva_pkg::ST_SEARCH;
            else if (is_ped && (item_ff.second_data < fva_pkg::PEDAL_ON_MIN) &&
                     (eff_mode <= fva_pkg::MODE_REASSIGN))
                                      state_in = fva_pkg::ST_VISSUE;
            else                      state_in = fva_pkg::ST_VEL;
         end
         fva_pkg::ST_PRESS:  state_in = fva_pkg::ST_VEL;
         fva_pkg::ST_SEARCH: begin
            priority if (srch_match) state_in = fva_pkg::ST_SHIFT;
            else if (!srch_more)     state_in = fva_pkg::ST_VISSUE;
         end
         fva_pkg::ST_SHIFT: begin
            if (!pend_ff && !shift_more) state_in = fva_pkg::ST_VISSUE;
         end
         fva_pkg::ST_VISSUE: begin
            priority if (vi_need_rd)                  state_in = fva_pkg::ST_VAPPLY;
            else if (kind_ff == fva_pkg::VK_UNISON)   state_in = fva_pkg::ST_VEL;
            else if (vi_ff == 2'd3)                   state_in = fva_pkg::ST_VEL;
         end
         fva_pkg::ST_VAPPLY: begin
            if ((kind_ff == fva_pkg::VK_UNISON) || (vi_ff == 2'd3))
               state_in = fva_pkg::ST_VEL;
            else
               state_in = fva_pkg::ST_VISSUE;
         end
         fva_pkg::ST_VEL: begin
            if (vc_ff == 3'd4) state_in = fva_pkg::ST_DONE;
         end
         fva_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = fva_pkg::ST_IDLE;
         end
         default: state_in = fva_pkg::ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // datapath and memory controls
   // ------------------------------------------------------------------
   always_comb begin : datapath
      logic [1:0] v;
      logic       push;
      logic [6:0] push_key;
      v        = 2'd0;
      push     = 1'b0;
      push_key = item_ff.first_data;

      mode_in   = mode_ff;
      filter_in = filter_ff;
      kind_in   = kind_ff;
      item_in   = item_ff;
      count_in  = count_ff;
      scan_in   = scan_ff;
      dst_in    = dst_ff;
      pend_in   = 1'b0;
      vi_in     = vi_ff;
      vc_in     = vc_ff;
      pedal_in  = pedal_ff;
      last_in   = last_ff;
      sp_in     = sp_ff;
      vvalid_in = vvalid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in    = rsp_ff;
      for (int i = 0; i < 4; i++) begin
         note_in[i] = note_ff[i];
         gate_in[i] = gate_ff[i];
         pg_in[i]   = pg_ff[i];
         vout_in[i] = vout_ff[i];
      end

      st_we    = 1'b0;
      st_waddr = count_ff[AW-1:0];
      st_wdata = push_key;
      st_raddr = scan_ff[AW-1:0];
      vm_we    = 1'b0;
      vm_waddr = item_ff.first_data;
      vm_wdata = item_ff.second_data;
      vm_raddr = note_ff[vc_ff[1:0]];

      if (csr_valid) begin
         unique case (csr_index)
            fva_pkg::CSR_POLY_MODE:      mode_in   = csr_data[2:0];
            fva_pkg::CSR_CHANNEL_FILTER: filter_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         fva_pkg::ST_IDLE: begin
            if (req_valid) item_in = req_data;
         end

         fva_pkg::ST_DECODE: begin
            vi_in   = 2'd0;
            vc_in   = 3'd0;
            scan_in = '0;
            priority if (eff_mode == fva_pkg::MODE_REASSIGN) kind_in = fva_pkg::VK_REAS_REL;
            else if (eff_mode == fva_pkg::MODE_UNISON)       kind_in = fva_pkg::VK_UNISON;
            else                                             kind_in = fva_pkg::VK_REL_POP;
            priority if (item_ff.cmd) begin
               for (int i = 0; i < 4; i++) begin
                  note_in[i] = fva_pkg::RESET_NOTE;
                  gate_in[i] = 1'b0;
                  pg_in[i]   = 1'b0;
               end
               pedal_in = 1'b0;
               last_in  = fva_pkg::NO_VOICE;
               sp_in    = 2'd0;
               count_in = '0;
            end else if (is_on) begin
               vm_we = 1'b1;
               vvalid_in[item_ff.first_data] = 1'b1;
            end else if (is_off) begin
               // kind already chosen above
            end else if (is_ped) begin
               if (item_ff.second_data >= fva_pkg::PEDAL_ON_MIN) begin
                  pedal_in = 1'b1;
                  for (int i = 0; i < 4; i++) pg_in[i] = gate_ff[i];
               end else begin
                  pedal_in = 1'b0;
                  for (int i = 0; i < 4; i++) pg_in[i] = 1'b0;
                  kind_in = (eff_mode == fva_pkg::MODE_REASSIGN) ?
                            fva_pkg::VK_REAS_PED : fva_pkg::VK_PED_POP;
               end
            end
         end

         fva_pkg::ST_PRESS: begin
            if (eff_mode == fva_pkg::MODE_UNISON) begin
               push = 1'b1;
               for (int i = 0; i < 4; i++) begin
                  note_in[i] = item_ff.first_data;
                  gate_in[i] = 1'b1;
                  pg_in[i]   = pedal_ff;
               end
            end else begin
               priority if ((eff_mode == fva_pkg::MODE_REUSE) && reuse_hit) begin
                  v = reuse_v;
               end else if (pick_found) begin
                  v     = pick_free;
                  sp_in = pick_free;
               end else begin
                  v     = pick_steal;
                  sp_in = pick_steal;
                  // stolen note goes onto the stack in the stealing modes
                  if ((eff_mode < fva_pkg::MODE_REASSIGN) && gate_ff[pick_steal]) begin
                     push     = 1'b1;
                     push_key = note_ff[pick_steal];
                  end
               end
               if (eff_mode == fva_pkg::MODE_REASSIGN) push = 1'b1;
               last_in    = {1'b0, v};
               note_in[v] = item_ff.first_data;
               gate_in[v] = 1'b1;
               pg_in[v]   = pedal_ff;
            end
            if (push && (count_ff < CW'(CACHE_DEPTH))) begin
               st_we    = 1'b1;
               st_wdata = push_key;
               count_in = count_ff + CW'(1);
            end
         end

         fva_pkg::ST_SEARCH: begin
            priority if (srch_match) begin
               dst_in = AW'(scan_ff - CW'(1));
            end else if (srch_more) begin
               scan_in = scan_ff + CW'(1);
               pend_in = 1'b1;
            end
         end

         fva_pkg::ST_SHIFT: begin
            if (pend_ff) begin
               st_we    = 1'b1;
               st_waddr = dst_ff;
               st_wdata = st_rdata;
               dst_in   = dst_ff + AW'(1);
            end
            if (shift_more) begin
               scan_in = scan_ff + CW'(1);
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               count_in = count_ff - CW'(1);
            end
         end

         fva_pkg::ST_VISSUE: begin
            st_raddr = (kind_ff == fva_pkg::VK_REAS_REL || kind_ff == fva_pkg::VK_REAS_PED) ?
                       AW'(vi_ff) : AW'(count_ff - CW'(1));
            if (!vi_need_rd) begin
               unique case (kind_ff)
                  fva_pkg::VK_REL_POP: begin
                     if (note_ff[vi_ff] == item_ff.first_data) gate_in[vi_ff] = 1'b0;
                  end
                  fva_pkg::VK_REAS_REL,
                  fva_pkg::VK_REAS_PED: gate_in[vi_ff] = 1'b0;
                  fva_pkg::VK_UNISON: begin
                     for (int i = 0; i < 4; i++) gate_in[i] = 1'b0;
                  end
                  default: ;
               endcase
               vi_in = vi_ff + 2'd1;
            end
         end

         fva_pkg::ST_VAPPLY: begin
            unique case (kind_ff)
               fva_pkg::VK_REL_POP: begin
                  note_in[vi_ff] = st_rdata;
                  count_in       = count_ff - CW'(1);
               end
               fva_pkg::VK_PED_POP: begin
                  note_in[vi_ff] = st_rdata;
                  gate_in[vi_ff] = 1'b1;
                  count_in       = count_ff - CW'(1);
               end
               fva_pkg::VK_REAS_REL: begin
                  if (!pg_ff[vi_ff]) note_in[vi_ff] = st_rdata;
                  pg_in[vi_ff] = pedal_ff;
               end
               fva_pkg::VK_REAS_PED: begin
                  note_in[vi_ff] = st_rdata;
                  gate_in[vi_ff] = 1'b1;
               end
               fva_pkg::VK_UNISON: begin
                  for (int i = 0; i < 4; i++) begin
                     note_in[i] = st_rdata;
                     gate_in[i] = 1'b1;
                  end
               end
               default: ;
            endcase
            vi_in = vi_ff + 2'd1;
         end

         fva_pkg::ST_VEL: begin
            if (vc_ff != 3'd0) begin
               vout_in[2'(vc_ff - 3'd1)] = vvld_rd_ff ? vm_rdata : 7'd0;
            end
            vc_in = vc_ff + 3'd1;
         end

         fva_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_in.note_zero      = note_ff[0];
               rsp_in.note_one       = note_ff[1];
               rsp_in.note_two       = note_ff[2];
               rsp_in.note_three     = note_ff[3];
               rsp_in.gate_zero      = gate_ff[0] || pg_ff[0];
               rsp_in.gate_one       = gate_ff[1] || pg_ff[1];
               rsp_in.gate_two       = gate_ff[2] || pg_ff[2];
               rsp_in.gate_three     = gate_ff[3] || pg_ff[3];
               rsp_in.velocity_zero  = vout_ff[0];
               rsp_in.velocity_one   = vout_ff[1];
               rsp_in.velocity_two   = vout_ff[2];
               rsp_in.velocity_three = vout_ff[3];
            end
         end

         default: ;
      endcase
   end

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fva_pkg::ST_IDLE;
         mode_ff      <= fva_pkg::MODE_RESET;
         filter_ff    <= 5'd0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         pedal_ff     <= 1'b0;
         last_ff      <= fva_pkg::NO_VOICE;
         sp_ff        <= 2'd0;
         vvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            note_ff[i] <= fva_pkg::RESET_NOTE;
            gate_ff[i] <= 1'b0;
            pg_ff[i]   <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         filter_ff    <= filter_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         pedal_ff     <= pedal_in;
         last_ff      <= last_in;
         sp_ff        <= sp_in;
         vvalid_ff    <= vvalid_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 4; i++) begin
            note_ff[i] <= note_in[i];
            gate_ff[i] <= gate_in[i];
            pg_ff[i]   <= pg_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      item_ff    <= item_in;
      scan_ff    <= scan_in;
      dst_ff     <= dst_in;
      vi_ff      <= vi_in;
      vc_ff      <= vc_in;
      rsp_ff     <= rsp_in;
      vvld_rd_ff <= vvalid_ff[vm_raddr];
      for (int i = 0; i < 4; i++) vout_ff[i] <= vout_in[i];
   end

   assign req_ready = (state_ff == fva_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CACHE_DEPTH))
      else $error("held count above cache depth");

   a_shift_dst: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fva_pkg::ST_SHIFT && st_we) |-> (CW'(dst_ff) < count_ff))
      else $error("shift writes past the held notes");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fva_pkg::ST_DONE && (!rsp_valid_ff || rsp_ready)) |=>
      (rsp_valid_ff && state_ff == fva_pkg::ST_IDLE))
      else $error("response not loaded on finish");
`endif

endmodule

// File: hw/rtl/fva_ram.sv
module fva_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
